// ----- hdl/blob_base_fee_exponential_macros.svh -----
// Assertion helpers shared by the RTL. All sample on clk, off during rst.
`ifndef BLOB_BASE_FEE_EXPONENTIAL_MACROS_SVH
`define BLOB_BASE_FEE_EXPONENTIAL_MACROS_SVH

// Same-cycle implication.
`define BBFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BBFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bbfe_pkg.sv -----
package bbfe_pkg;

  // Limb width of the series arithmetic and of the input and config fields.
  localparam int LIMB_W = 64;
  // Width of the series divisor d * i.
  localparam int DIVR_W = 2 * LIMB_W;
  // Width of the returned fee.
  localparam int FEE_W  = 2 * LIMB_W;

  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [DIVR_W-1:0] divr_t;

endpackage

// ----- hdl/bbfe_div.sv -----
// Restoring divider, one quotient bit per cycle, numerator MSB first.
// The numerator shift register takes quotient bits in at the bottom.
module bbfe_div #(
  parameter int NUM_W = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  bbfe_pkg::divr_t    dvs,
  output logic               done,
  output logic [NUM_W-1:0]   quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0]          nsh;
  bbfe_pkg::divr_t           rem;
  bbfe_pkg::divr_t           dvs_q;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;

  logic [bbfe_pkg::DIVR_W:0] rem_sh;
  logic [bbfe_pkg::DIVR_W:0] rem_sub;
  logic                      ge;

  // One restoring step: shift in the next numerator bit, try the subtract
  always_comb begin
    rem_sh  = {rem, nsh[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    ge      = !rem_sub[bbfe_pkg::DIVR_W];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      nsh   <= num;
      rem   <= '0;
      dvs_q <= dvs;
    end else if (busy) begin
      nsh <= {nsh[NUM_W-2:0], ge};
      rem <= ge ? rem_sub[bbfe_pkg::DIVR_W-1:0] : rem_sh[bbfe_pkg::DIVR_W-1:0];
    end
  end

  assign quo = nsh;

endmodule

// ----- hdl/blob_base_fee_exponential.sv -----
// Blob base fee exponential: for each excess_gas beat x and the configured
// update_fraction d, sums the integer series of d*e^(x/d) with term = d,
// term = floor(term*x / (d*i)), and returns floor(sum/d) as a 128-bit fee,
// or invalid with a zero fee on accumulator carry, sum reaching d*2^128,
// product overflow, index exhaustion, zero d, or a fee wider than 128 bits.
// One item at a time: each series term runs the add and check, the cap
// compare, the shift-add multiply by x (MSB of x first) and the
// one-bit-per-cycle restoring divider; the final division by d reuses the
// divider. The next beat can be taken from the cycle in which the result
// appears, and a new beat is taken while the last result still waits.
`include "blob_base_fee_exponential_macros.svh"

module blob_base_fee_exponential #(
  parameter int ACC_LIMBS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  bbfe_pkg::limb_t       cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bbfe_pkg::limb_t       excess_gas,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bbfe_pkg::limb_t       fee_low,
  output bbfe_pkg::limb_t       fee_high,
  output logic                  invalid
);

  localparam int W     = ACC_LIMBS * bbfe_pkg::LIMB_W;
  localparam int MCNT_W = $clog2(bbfe_pkg::LIMB_W);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_DGO   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_FGO   = 4'd6;
  localparam logic [3:0] S_FDIV  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]             state;
  bbfe_pkg::limb_t        upd_frac;
  bbfe_pkg::limb_t        x;
  bbfe_pkg::limb_t        xsh;
  bbfe_pkg::limb_t        iter;
  bbfe_pkg::divr_t        div_d;
  logic [W-1:0]           acc;
  logic [W-1:0]           term;
  logic [W-1:0]           prod;
  logic                   mov;
  logic [MCNT_W-1:0]      mcnt;
  logic [bbfe_pkg::FEE_W-1:0] res_fee;
  logic                   res_bad;

  logic [W:0]             add_sum;
  logic [W:0]             mul_sum;
  logic                   mov_next;
  logic                   cap_hit;
  logic                   div_start;
  logic [W-1:0]           div_num;
  bbfe_pkg::divr_t        div_dvs;
  logic                   div_done;
  logic [W-1:0]           div_quo;
  logic                   out_load;

  // Series arithmetic: accumulate, cap compare, one Horner step of term*x
  always_comb begin
    add_sum  = {1'b0, acc} + {1'b0, term};
    cap_hit  = acc[W-1:bbfe_pkg::FEE_W] >= (W - bbfe_pkg::FEE_W)'(upd_frac);
    mul_sum  = {1'b0, prod[W-2:0], 1'b0} + {1'b0, (xsh[bbfe_pkg::LIMB_W-1] ? term : '0)};
    mov_next = mov | prod[W-1] | mul_sum[W];
  end

  // Shared divider: term update and final fee
  assign div_start = (state == S_DGO) || (state == S_FGO);
  assign div_num   = (state == S_FGO) ? acc : prod;
  assign div_dvs   = (state == S_FGO) ? bbfe_pkg::divr_t'(upd_frac) : div_d;

  bbfe_div #(
    .NUM_W (W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .dvs   (div_dvs),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      upd_frac <= '0;
    end else if (cfg_we) begin
      upd_frac <= cfg_wdata;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_CHECK;
        end
        S_CHECK: begin
          if (term == '0) state <= S_FGO;
          else if (add_sum[W]) state <= S_DONE;
          else state <= S_CMP;
        end
        S_CMP: begin
          state <= cap_hit ? S_DONE : S_MUL;
        end
        S_MUL: begin
          if (mcnt == MCNT_W'(bbfe_pkg::LIMB_W - 1)) state <= mov_next ? S_DONE : S_DGO;
        end
        S_DGO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state <= (iter == '1) ? S_DONE : S_CHECK;
        end
        S_FGO: begin
          state <= S_FDIV;
        end
        S_FDIV: begin
          if (div_done) state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Series datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        x       <= excess_gas;
        term    <= W'(upd_frac);
        acc     <= '0;
        div_d   <= bbfe_pkg::divr_t'(upd_frac);
        iter    <= bbfe_pkg::LIMB_W'(1);
        res_bad <= 1'b0;
      end
      S_CHECK: begin
        if (term != '0) begin
          acc <= add_sum[W-1:0];
          if (add_sum[W]) res_bad <= 1'b1;
        end
      end
      S_CMP: begin
        if (cap_hit) res_bad <= 1'b1;
        prod <= '0;
        mov  <= 1'b0;
        mcnt <= '0;
        xsh  <= x;
      end
      S_MUL: begin
        prod <= mul_sum[W-1:0];
        mov  <= mov_next;
        mcnt <= mcnt + 1'b1;
        xsh  <= {xsh[bbfe_pkg::LIMB_W-2:0], 1'b0};
        if (mcnt == MCNT_W'(bbfe_pkg::LIMB_W - 1) && mov_next) res_bad <= 1'b1;
      end
      S_DIV: begin
        if (div_done) begin
          term  <= div_quo;
          iter  <= iter + 1'b1;
          div_d <= div_d + bbfe_pkg::divr_t'(upd_frac);
          if (iter == '1) res_bad <= 1'b1;
        end
      end
      S_FDIV: begin
        if (div_done) begin
          res_fee <= div_quo[bbfe_pkg::FEE_W-1:0];
          if (div_quo[W-1:bbfe_pkg::FEE_W] != '0) res_bad <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      fee_low  <= res_bad ? '0 : res_fee[bbfe_pkg::LIMB_W-1:0];
      fee_high <= res_bad ? '0 : res_fee[bbfe_pkg::FEE_W-1:bbfe_pkg::LIMB_W];
      invalid  <= res_bad;
    end
  end

  // Checks
  `BBFE_ASSERT_NOW(a_bad_fee_zero, out_valid && invalid, {fee_high, fee_low} == '0, "bad fee")
  `BBFE_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state == S_CHECK, "no start")
  `BBFE_ASSERT_NOW(a_div_done_owned, div_done, state == S_DIV || state == S_FDIV, "stray done")
  `BBFE_ASSERT_NOW(a_out_from_done, $rose(out_valid), $past(state) == S_DONE, "stray beat")

endmodule
